@@ rtl/lpl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lpl_pkg;

  // Sample and level widths
  localparam int SAMPLE_BITS = 24;
  localparam int LEVEL_BITS  = 24;
  localparam int COEF_BITS   = 16;

  // Delay line geometry (depth is a power of two, so the ring wraps naturally)
  localparam int DELAY_DEPTH    = 1024;
  localparam int ADDR_BITS      = $clog2(DELAY_DEPTH);
  localparam int DELAY_CFG_BITS = 10;

  // Serial multiplier: signed multiplicand, unsigned multiplier shifted out LSB first
  localparam int MC_BITS   = LEVEL_BITS + 1;
  localparam int MP_BITS   = LEVEL_BITS;
  localparam int STEP_BITS = $clog2(MP_BITS + 1);

  localparam logic [STEP_BITS-1:0] BLEND_STEPS = STEP_BITS'(COEF_BITS);
  localparam logic [STEP_BITS-1:0] APPLY_STEPS = STEP_BITS'(MP_BITS);
  localparam logic [STEP_BITS-1:0] DIV_STEPS   = STEP_BITS'(LEVEL_BITS - 1);

  localparam logic [LEVEL_BITS-1:0] GAIN_ONE = LEVEL_BITS'(8388608);

  // Configuration port
  localparam int CFG_BITS     = 24;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SMOOTH     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LIMITER_ON = 3'd5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [LEVEL_BITS-1:0]         level_t;

  // Start strobe and step count for a serial multiplier
  typedef struct packed {
    logic                 start;
    logic [STEP_BITS-1:0] steps;
  } lpl_mul_ctl_t;

endpackage

`default_nettype wire

@@ rtl/lookahead_peak_limiter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Stereo look-ahead peak limiter.
// Input words (in_left_in, in_right_in) and result words (out_left_out, out_right_out,
// out_gain_now, out_envelope_now) move on valid/ready channels; configuration is a
// plain write port (cfg_we, cfg_index, cfg_data), to be written only while the block
// is idle; the block itself does not enforce this. One word is processed at a time.
// With the limiter on, the result comes from passes that run one bit per cycle: the
// envelope blend and the gain blend on serial multiplier A, then the apply pass on
// multipliers A and B, one per channel; when the envelope is above threshold, a serial
// divider pass sets the target gain before the gain blend. In bypass the word goes
// straight to the output state. A new word is taken only once the block is back in idle.
// in_ready rises at the edge that loads the result into the output register, so a
// stalled receiver holds the finished word there while the next input word is taken
// and worked on; the block then waits with its next result until the register frees.
// Reset (synchronous, active low) restores register defaults, envelope 0 and unity
// gain, and empties the delay line at once: untouched slots read as zero through a
// write-pointer fill mark, so no clearing pass is needed.
module lookahead_peak_limiter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lpl_pkg::sample_t                  in_left_in,
  input  lpl_pkg::sample_t                  in_right_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lpl_pkg::sample_t                  out_left_out,
  output lpl_pkg::sample_t                  out_right_out,
  output lpl_pkg::level_t                   out_gain_now,
  output lpl_pkg::level_t                   out_envelope_now,
  input  logic                              cfg_we,
  input  logic [lpl_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lpl_pkg::CFG_BITS-1:0]      cfg_data
);
  import lpl_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_ENV  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_GBL  = 3'd5;
  localparam logic [2:0] S_APP  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Configuration registers
  level_t                    thr_r;
  logic [COEF_BITS-1:0]      atk_r;
  logic [COEF_BITS-1:0]      rel_r;
  logic [COEF_BITS-1:0]      smo_r;
  logic [DELAY_CFG_BITS-1:0] dly_r;
  logic                      on_r;

  // Processing state
  level_t  env_r;
  level_t  gain_r;
  level_t  peak_r;
  level_t  tgt_r;
  sample_t res_l_r;
  sample_t res_r_r;
  logic    out_valid_r;
  sample_t out_l_r;
  sample_t out_rr_r;
  level_t  out_gain_r;
  level_t  out_env_r;

  logic    in_fire;
  logic    out_free;
  level_t  mag_l;
  level_t  mag_r;
  level_t  peak;
  logic    dl_start;
  sample_t dl_left;
  sample_t dl_right;

  lpl_mul_ctl_t              ctl_a;
  lpl_mul_ctl_t              ctl_b;
  logic signed [MC_BITS-1:0] mc_a;
  logic signed [MC_BITS-1:0] mc_b;
  logic [MP_BITS-1:0]        mp_a;
  logic [MP_BITS-1:0]        mp_b;
  logic                      done_a;
  logic                      done_b;
  logic signed [MC_BITS-1:0] hi_a;
  logic signed [MC_BITS-1:0] hi_b;
  logic [MP_BITS-1:0]        lo_a;
  logic [MP_BITS-1:0]        lo_b;

  logic                      div_start;
  logic                      div_done;
  level_t                    quo;

  logic [COEF_BITS-1:0]      env_coef;
  logic signed [MC_BITS-1:0] env_diff;
  logic signed [MC_BITS-1:0] env_sum;
  level_t                    tgt;
  logic signed [MC_BITS-1:0] gain_diff;
  logic signed [MC_BITS-1:0] gain_sum;
  level_t                    gain_blend;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Peak magnitude of the incoming pair
  assign mag_l = in_left_in[SAMPLE_BITS-1]  ? LEVEL_BITS'(-in_left_in)  : LEVEL_BITS'(in_left_in);
  assign mag_r = in_right_in[SAMPLE_BITS-1] ? LEVEL_BITS'(-in_right_in) : LEVEL_BITS'(in_right_in);
  assign peak  = (mag_l > mag_r) ? mag_l : mag_r;

  // Blend terms: new = x + floor(c * (old - x) / 2^16)
  assign env_coef   = (peak_r > env_r) ? atk_r : rel_r;
  assign env_diff   = $signed({1'b0, env_r}) - $signed({1'b0, peak_r});
  assign env_sum    = $signed({1'b0, peak_r}) + hi_a;
  assign tgt        = (state_r == S_DIV) ? quo : ((state_r == S_CMP) ? GAIN_ONE : tgt_r);
  assign gain_diff  = $signed({1'b0, gain_r}) - $signed({1'b0, tgt});
  assign gain_sum   = $signed({1'b0, tgt}) + hi_a;
  assign gain_blend = gain_sum[LEVEL_BITS-1:0];

  assign dl_start = in_fire && on_r;

  lpl_delay u_delay (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dl_start),
    .wr_left  (in_left_in),
    .wr_right (in_right_in),
    .delay    (dly_r),
    .rd_left  (dl_left),
    .rd_right (dl_right)
  );

  lpl_sermul u_mul_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_a),
    .mcand   (mc_a),
    .mplier  (mp_a),
    .done    (done_a),
    .prod_hi (hi_a),
    .prod_lo (lo_a)
  );

  lpl_sermul u_mul_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_b),
    .mcand   (mc_b),
    .mplier  (mp_b),
    .done    (done_b),
    .prod_hi (hi_b),
    .prod_lo (lo_b)
  );

  lpl_serdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (thr_r),
    .den   (env_r),
    .done  (div_done),
    .quo   (quo)
  );

  // Sequence the shared units
  always_comb begin
    state_nxt = state_r;
    ctl_a     = '0;
    ctl_b     = '0;
    mc_a      = '0;
    mc_b      = '0;
    mp_a      = '0;
    mp_b      = '0;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = on_r ? S_READ : S_OUT;
        end
      end
      S_READ: begin
        ctl_a.start = 1'b1;
        ctl_a.steps = BLEND_STEPS;
        mc_a        = env_diff;
        mp_a        = MP_BITS'(env_coef);
        state_nxt   = S_ENV;
      end
      S_ENV: begin
        if (done_a) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (env_r > thr_r) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          ctl_a.start = 1'b1;
          ctl_a.steps = BLEND_STEPS;
          mc_a        = gain_diff;
          mp_a        = MP_BITS'(smo_r);
          state_nxt   = S_GBL;
        end
      end
      S_DIV: begin
        if (div_done) begin
          ctl_a.start = 1'b1;
          ctl_a.steps = BLEND_STEPS;
          mc_a        = gain_diff;
          mp_a        = MP_BITS'(smo_r);
          state_nxt   = S_GBL;
        end
      end
      S_GBL: begin
        if (done_a) begin
          ctl_a.start = 1'b1;
          ctl_a.steps = APPLY_STEPS;
          mc_a        = MC_BITS'(dl_left);
          mp_a        = MP_BITS'(gain_blend);
          ctl_b.start = 1'b1;
          ctl_b.steps = APPLY_STEPS;
          mc_b        = MC_BITS'(dl_right);
          mp_b        = MP_BITS'(gain_blend);
          state_nxt   = S_APP;
        end
      end
      S_APP: begin
        if (done_a && done_b) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, configuration and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= GAIN_ONE;
      atk_r       <= '0;
      rel_r       <= '0;
      smo_r       <= '0;
      dly_r       <= '0;
      on_r        <= 1'b1;
      env_r       <= '0;
      gain_r      <= GAIN_ONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD:  thr_r <= cfg_data[LEVEL_BITS-1:0];
          CFG_ATTACK:     atk_r <= cfg_data[COEF_BITS-1:0];
          CFG_RELEASE:    rel_r <= cfg_data[COEF_BITS-1:0];
          CFG_SMOOTH:     smo_r <= cfg_data[COEF_BITS-1:0];
          CFG_DELAY:      dly_r <= cfg_data[DELAY_CFG_BITS-1:0];
          CFG_LIMITER_ON: on_r  <= cfg_data[0];
          default: ;
        endcase
      end

      // Bypass drops the envelope and restores unity gain
      if (in_fire && !on_r) begin
        env_r  <= '0;
        gain_r <= GAIN_ONE;
      end
      if (state_r == S_ENV && done_a) begin
        env_r <= env_sum[LEVEL_BITS-1:0];
      end
      if (state_r == S_GBL && done_a) begin
        gain_r <= gain_blend;
      end

      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      peak_r  <= peak;
      res_l_r <= in_left_in;
      res_r_r <= in_right_in;
    end
    // Hold the target gain for the smoothing pass
    if (state_r == S_CMP) begin
      tgt_r <= GAIN_ONE;
    end
    if (state_r == S_DIV && div_done) begin
      tgt_r <= quo;
    end
    // Keep product bits 23 and up: floor(x * g / 2^23)
    if (state_r == S_APP && done_a) begin
      res_l_r <= {hi_a[SAMPLE_BITS-2:0], lo_a[MP_BITS-1]};
      res_r_r <= {hi_b[SAMPLE_BITS-2:0], lo_b[MP_BITS-1]};
    end
    if (state_r == S_OUT && out_free) begin
      out_l_r    <= res_l_r;
      out_rr_r   <= res_r_r;
      out_gain_r <= gain_r;
      out_env_r  <= env_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_out     = out_l_r;
  assign out_right_out    = out_rr_r;
  assign out_gain_now     = out_gain_r;
  assign out_envelope_now = out_env_r;

endmodule

`default_nettype wire

@@ rtl/lpl_sermul.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shift-add multiplier, one multiplier bit per cycle.
// After n steps: product = prod_hi * 2^n + prod_lo[top n bits], prod_hi = floor(product / 2^n).
module lpl_sermul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lpl_pkg::lpl_mul_ctl_t             ctl,
  input  logic signed [lpl_pkg::MC_BITS-1:0] mcand,
  input  logic [lpl_pkg::MP_BITS-1:0]       mplier,
  output logic                              done,
  output logic signed [lpl_pkg::MC_BITS-1:0] prod_hi,
  output logic [lpl_pkg::MP_BITS-1:0]       prod_lo
);
  import lpl_pkg::*;

  logic                      run_r;
  logic                      done_r;
  logic [STEP_BITS-1:0]      cnt_r;
  logic signed [MC_BITS-1:0] mc_r;
  logic signed [MC_BITS-1:0] hi_r;
  logic [MP_BITS-1:0]        mp_r;
  logic [MP_BITS-1:0]        lo_r;
  logic signed [MC_BITS:0]   sum;

  // Add the multiplicand when the current multiplier bit is set
  assign sum = {hi_r[MC_BITS-1], hi_r} + (mp_r[0] ? {mc_r[MC_BITS-1], mc_r} : '0);

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == STEP_BITS'(1));
      if (ctl.start) begin
        run_r <= 1'b1;
        cnt_r <= ctl.steps;
      end else if (run_r) begin
        cnt_r <= cnt_r - STEP_BITS'(1);
        if (cnt_r == STEP_BITS'(1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  // Shift the partial product right by one bit per step
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mc_r <= mcand;
      mp_r <= mplier;
      hi_r <= '0;
      lo_r <= '0;
    end else if (run_r) begin
      hi_r <= sum[MC_BITS:1];
      lo_r <= {sum[0], lo_r[MP_BITS-1:1]};
      mp_r <= mp_r >> 1;
    end
  end

  assign done    = done_r;
  assign prod_hi = hi_r;
  assign prod_lo = lo_r;

endmodule

`default_nettype wire

@@ rtl/lpl_serdiv.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider for (num << 23) / den, one quotient bit per cycle.
// Valid only for num < den; the quotient then fits 23 bits.
module lpl_serdiv (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  lpl_pkg::level_t        num,
  input  lpl_pkg::level_t        den,
  output logic                   done,
  output lpl_pkg::level_t        quo
);
  import lpl_pkg::*;

  logic                       run_r;
  logic                       done_r;
  logic [STEP_BITS-1:0]       cnt_r;
  level_t                     rem_r;
  level_t                     den_r;
  logic [LEVEL_BITS-2:0]      q_r;
  logic [LEVEL_BITS:0]        shifted;
  logic                       fits;

  // Trial subtract of the shifted remainder
  assign shifted = {rem_r, 1'b0};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == STEP_BITS'(1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= DIV_STEPS;
      end else if (run_r) begin
        cnt_r <= cnt_r - STEP_BITS'(1);
        if (cnt_r == STEP_BITS'(1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  // Remainder stays below den, so it fits back into LEVEL_BITS
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= fits ? LEVEL_BITS'(shifted - {1'b0, den_r}) : LEVEL_BITS'(shifted);
      q_r   <= {q_r[LEVEL_BITS-3:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = {1'b0, q_r};

endmodule

`default_nettype wire

@@ rtl/lpl_delay.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Ring delay line for the stereo pair. Slots never written since reset read as zero:
// writes fill the ring in order from slot 0, so a slot below the write pointer,
// or any slot once the ring has wrapped, holds real data.
module lpl_delay (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  lpl_pkg::sample_t                    wr_left,
  input  lpl_pkg::sample_t                    wr_right,
  input  logic [lpl_pkg::DELAY_CFG_BITS-1:0]  delay,
  output lpl_pkg::sample_t                    rd_left,
  output lpl_pkg::sample_t                    rd_right
);
  import lpl_pkg::*;

  logic [2*SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
  logic [2*SAMPLE_BITS-1:0] q_r;
  logic [2*SAMPLE_BITS-1:0] fwd_r;
  logic [ADDR_BITS-1:0]     wp_r;
  logic                     full_r;
  logic                     ok_r;
  logic                     zero_r;
  logic [ADDR_BITS-1:0]     rp;
  logic [ADDR_BITS-1:0]     dly;
  logic [2*SAMPLE_BITS-1:0] rd_word;

  assign dly = ADDR_BITS'(delay);
  assign rp  = wp_r - dly;

  // Write pointer and wrap flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      full_r <= 1'b0;
      ok_r   <= 1'b0;
      zero_r <= 1'b0;
    end else if (start) begin
      wp_r   <= wp_r + ADDR_BITS'(1);
      if (wp_r == ADDR_BITS'(DELAY_DEPTH - 1)) begin
        full_r <= 1'b1;
      end
      ok_r   <= full_r || (rp < wp_r);
      zero_r <= (dly == '0);
    end
  end

  // Read old slot, write new pair, keep the new pair for zero delay
  always_ff @(posedge clk) begin
    if (start) begin
      q_r        <= mem[rp];
      mem[wp_r]  <= {wr_left, wr_right};
      fwd_r      <= {wr_left, wr_right};
    end
  end

  always_comb begin
    if (zero_r) begin
      rd_word = fwd_r;
    end else if (ok_r) begin
      rd_word = q_r;
    end else begin
      rd_word = '0;
    end
  end

  assign rd_left  = rd_word[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign rd_right = rd_word[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

@@ rtl/lpl_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpl_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input lpl_pkg::sample_t out_left_out,
  input lpl_pkg::level_t  out_gain_now,
  input lpl_pkg::level_t  out_envelope_now
);
  import lpl_pkg::*;

  // Coming out of reset: idle, output empty
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("not idle after reset");

  // One word in flight: ready drops after every accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while busy");

  // Gain never above unity, envelope never above full scale
  a_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gain_now <= GAIN_ONE && out_envelope_now <= GAIN_ONE))
    else $error("gain or envelope out of range");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_left_out)
                                   && $stable(out_gain_now)))
    else $error("result changed while stalled");

endmodule

bind lookahead_peak_limiter lpl_checker u_lpl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_left_out     (out_left_out),
  .out_gain_now     (out_gain_now),
  .out_envelope_now (out_envelope_now)
);

`default_nettype wire

@@ dv/lookahead_peak_limiter_tb.sv @@
`timescale 1ns / 1ps

module lookahead_peak_limiter_tb;
  import lpl_pkg::*;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 3'd7;

  localparam longint COEF_UNITY = 65536;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } in_word_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
    level_t  gain;
    level_t  env;
  } result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  sample_t                 in_left_in = '0;
  sample_t                 in_right_in = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  sample_t                 out_left_out;
  sample_t                 out_right_out;
  level_t                  out_gain_now;
  level_t                  out_envelope_now;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_data = '0;

  lookahead_peak_limiter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_left_in       (in_left_in),
    .in_right_in      (in_right_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_out     (out_left_out),
    .out_right_out    (out_right_out),
    .out_gain_now     (out_gain_now),
    .out_envelope_now (out_envelope_now),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #1 clk = ~clk;

  in_word_t pending_words[$];
  result_t  expected_words[$];
  int       fail_count = 0;
  int       send_gap = 0;
  int       stall_len = 0;
  bit       no_idle = 1'b0;

  // Limiter state mirror
  sample_t          hist_left[DELAY_DEPTH];
  sample_t          hist_right[DELAY_DEPTH];
  logic [ADDR_BITS-1:0] wr_slot;
  longint           env_lvl;
  longint           gain_lvl;

  // Register mirror
  longint                    thr_reg;
  longint                    attack_reg;
  longint                    release_reg;
  longint                    smooth_reg;
  logic [DELAY_CFG_BITS-1:0] delay_reg;
  logic                      on_reg;

  initial begin
    for (int i = 0; i < DELAY_DEPTH; i++) begin
      hist_left[i]  = '0;
      hist_right[i] = '0;
    end
    wr_slot     = '0;
    env_lvl     = 0;
    gain_lvl    = longint'(GAIN_ONE);
    thr_reg     = 8388608;
    attack_reg  = 0;
    release_reg = 0;
    smooth_reg  = 0;
    delay_reg   = '0;
    on_reg      = 1'b1;
  end

  // One-pole blend in Q0.16: c retains the old value
  function automatic longint blend16(longint c, longint old_v, longint x);
    return (c * old_v + (COEF_UNITY - c) * x) >> 16;
  endfunction

  // Advance the limiter mirror by one word and return the result it yields
  function automatic result_t limiter_step(sample_t l, sample_t r);
    result_t              res;
    longint               sl, sr, al, ar, peak, target, pl, pr;
    logic [ADDR_BITS-1:0] rd_slot;
    sl = longint'(l);
    sr = longint'(r);
    if (!on_reg) begin
      env_lvl   = 0;
      gain_lvl  = longint'(GAIN_ONE);
      res.left  = l;
      res.right = r;
      res.gain  = GAIN_ONE;
      res.env   = '0;
      return res;
    end
    rd_slot = wr_slot - delay_reg;
    hist_left[wr_slot]  = l;
    hist_right[wr_slot] = r;
    al   = (sl < 0) ? -sl : sl;
    ar   = (sr < 0) ? -sr : sr;
    peak = (al > ar) ? al : ar;
    if (peak > env_lvl) env_lvl = blend16(attack_reg, env_lvl, peak);
    else env_lvl = blend16(release_reg, env_lvl, peak);
    target = longint'(GAIN_ONE);
    if (env_lvl > thr_reg) target = (thr_reg << 23) / env_lvl;
    gain_lvl = blend16(smooth_reg, gain_lvl, target);
    // arithmetic shift floors the product
    pl = (longint'(hist_left[rd_slot]) * gain_lvl) >>> 23;
    pr = (longint'(hist_right[rd_slot]) * gain_lvl) >>> 23;
    wr_slot   = wr_slot + ADDR_BITS'(1);
    res.left  = pl[SAMPLE_BITS-1:0];
    res.right = pr[SAMPLE_BITS-1:0];
    res.gain  = gain_lvl[LEVEL_BITS-1:0];
    res.env   = env_lvl[LEVEL_BITS-1:0];
    return res;
  endfunction

  // Idle length: mostly short, a few long
  function automatic int idle_len();
    int pick;
    if (no_idle) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  // Drive input words from the pending queue
  always @(posedge clk) begin : drive_input
    in_word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) expected_words.push_back(limiter_step(in_left_in, in_right_in));
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          nxt = pending_words.pop_front();
          in_left_in  <= nxt.left;
          in_right_in <= nxt.right;
          in_valid    <= 1'b1;
          send_gap    <= idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check result words against the oldest expectation; stall the receiver at random
  always @(posedge clk) begin : watch_output
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_len <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word arrived with none expected");
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_left_out !== want.left) begin
            $error("left_out: expected %0d, got %0d", want.left, out_left_out);
            fail_count++;
          end
          if (out_right_out !== want.right) begin
            $error("right_out: expected %0d, got %0d", want.right, out_right_out);
            fail_count++;
          end
          if (out_gain_now !== want.gain) begin
            $error("gain_now: expected %0d, got %0d", want.gain, out_gain_now);
            fail_count++;
          end
          if (out_envelope_now !== want.env) begin
            $error("envelope_now: expected %0d, got %0d", want.env, out_envelope_now);
            fail_count++;
          end
        end
      end
      if (stall_len != 0) begin
        stall_len <= stall_len - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_len <= idle_len();
      end
    end
  end

  // Hold until every queued word is sent and every result has come back
  task automatic wait_drained();
    @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
      @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_THRESHOLD:  thr_reg     = longint'(data);
      CFG_ATTACK:     attack_reg  = longint'(data[COEF_BITS-1:0]);
      CFG_RELEASE:    release_reg = longint'(data[COEF_BITS-1:0]);
      CFG_SMOOTH:     smooth_reg  = longint'(data[COEF_BITS-1:0]);
      CFG_DELAY:      delay_reg   = data[DELAY_CFG_BITS-1:0];
      CFG_LIMITER_ON: on_reg      = data[0];
      default: ;
    endcase
  endtask

  task automatic push_pair(int l, int r);
    in_word_t w;
    w.left  = sample_t'(l);
    w.right = sample_t'(r);
    pending_words.push_back(w);
  endtask

  function automatic int rand_sample(int amp);
    int v;
    v = int'($urandom_range(0, 2 * amp)) - amp;
    if (v > 8388607) v = 8388607;
    return v;
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_coeff();
    logic [COEF_BITS-1:0] c;
    case ($urandom_range(0, 5))
      0:       c = '0;
      1:       c = 16'hFFFF;
      2:       c = COEF_BITS'(16'hFFFF - $urandom_range(0, 255));
      default: c = COEF_BITS'($urandom_range(0, 65535));
    endcase
    return {8'($urandom), c};
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_threshold();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 24'h800000;
      2:       return 24'hFFFFFF;
      3:       return CFG_BITS'($urandom_range(24'h800001, 24'hFFFFFF));
      4:       return CFG_BITS'($urandom_range(0, 24'h010000));
      default: return CFG_BITS'($urandom_range(1, 24'h800000));
    endcase
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_delay();
    logic [DELAY_CFG_BITS-1:0] d;
    case ($urandom_range(0, 4))
      0:       d = '0;
      1:       d = '1;
      2:       d = DELAY_CFG_BITS'($urandom_range(1, 8));
      default: d = DELAY_CFG_BITS'($urandom_range(0, 1023));
    endcase
    return {14'($urandom), d};
  endfunction

  // Stimulus: directed corners, then phases of bursts at random levels
  initial begin : stimulus
    int n, len, amp;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: full-scale threshold, instant envelope and gain, no delay
    push_pair(8388607, -8388608);
    push_pair(-8388608, 8388607);
    push_pair(0, 0);
    push_pair(-1, 1);
    push_pair(1, -1);
    push_pair(4194304, -4194304);
    wait_drained();

    // zero threshold: any nonzero envelope drives the gain to zero
    cfg_write(CFG_THRESHOLD, '0);
    cfg_write(CFG_DELAY, 24'd1);
    push_pair(100, -5);
    push_pair(0, 0);
    push_pair(0, 0);
    push_pair(-8388608, 0);
    wait_drained();

    // threshold above full scale, slowest coefficients, longest delay
    cfg_write(CFG_THRESHOLD, 24'hFFFFFF);
    cfg_write(CFG_ATTACK, 24'h00FFFF);
    cfg_write(CFG_RELEASE, 24'h00FFFF);
    cfg_write(CFG_SMOOTH, 24'h00FFFF);
    cfg_write(CFG_DELAY, 24'd1023);
    push_pair(-8388608, -8388608);
    push_pair(8388607, 8388607);
    push_pair(-3, 7);
    wait_drained();

    // limiting active with moderate coefficients
    cfg_write(CFG_THRESHOLD, 24'd2097152);
    cfg_write(CFG_ATTACK, '0);
    cfg_write(CFG_RELEASE, 24'd32768);
    cfg_write(CFG_SMOOTH, 24'd16384);
    cfg_write(CFG_DELAY, 24'd2);
    push_pair(8000000, -100);
    push_pair(-7000000, 6000000);
    push_pair(12, -12);
    push_pair(0, 0);
    push_pair(-8388608, 8388607);
    wait_drained();

    // bypass, writes to unused indexes, then back on
    cfg_write(CFG_LIMITER_ON, '0);
    push_pair(8388607, -8388608);
    push_pair(-1, 0);
    push_pair(123456, -654321);
    wait_drained();
    cfg_write(CFG_SPARE_A, 24'hFFFFFF);
    cfg_write(CFG_SPARE_B, 24'h5A5A5A);
    cfg_write(CFG_LIMITER_ON, 24'd1);
    push_pair(5000000, -5000000);
    push_pair(1, 1);

    for (int ph = 0; ph < 16; ph++) begin
      wait_drained();
      no_idle = (ph % 5 == 3);
      cfg_write(CFG_THRESHOLD, pick_threshold());
      cfg_write(CFG_ATTACK, pick_coeff());
      cfg_write(CFG_RELEASE, pick_coeff());
      cfg_write(CFG_SMOOTH, pick_coeff());
      cfg_write(CFG_DELAY, pick_delay());
      cfg_write(CFG_LIMITER_ON, {23'($urandom), ($urandom_range(0, 5) != 0)});
      if ($urandom_range(0, 3) == 0)
        cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 24'($urandom));
      n = 0;
      while (n < 125) begin
        len = $urandom_range(4, 40);
        if ($urandom_range(0, 9) == 0) begin
          // noise: full-range words
          for (int i = 0; i < len; i++) push_pair(int'($urandom), int'($urandom));
        end else begin
          // burst at one level so the envelope climbs, holds and decays
          if ($urandom_range(0, 4) == 0) amp = 8388608;
          else amp = $urandom_range(0, 1 << $urandom_range(0, 23));
          for (int i = 0; i < len; i++) push_pair(rand_sample(amp), rand_sample(amp));
        end
        n += len;
      end
    end

    no_idle = 1'b0;
    wait_drained();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
